// File: design/gtl_pkg.sv
// Shared types, codes and field widths for the glyph text layout block.
`default_nettype none

package gtl_pkg;

    localparam int CH_W          = 8;
    localparam int GLYPH_CODE_W  = 7;
    localparam int AW_W          = 13;
    localparam int GW_W          = 7;
    localparam int IN_COORD_W    = 16;
    localparam int OUT_COORD_W   = 16;
    localparam int SCALE_W       = 8;
    localparam int STEP_W        = 15;
    localparam int CHGW_W        = 14;
    localparam int V_W           = 14;
    localparam int VSUM_W        = 15;
    localparam int ATLAS_COORD_W = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;

    localparam logic [CH_W-1:0] CODE_TAB     = 8'd9;
    localparam logic [CH_W-1:0] CODE_NEWLINE = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_WIDTH,
        CFG_ATLAS_HEIGHT,
        CFG_GLYPH_WIDTH,
        CFG_GLYPH_HEIGHT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_TAB,
        DIV_COLS,
        DIV_U,
        DIV_ROW
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NEWLINE,
        S_TAB_PREP,
        S_TAB_GO,
        S_TAB_WAIT,
        S_TAB_UPD,
        S_COLS_GO,
        S_COLS_WAIT,
        S_U_GO,
        S_U_WAIT,
        S_ROW_GO,
        S_ROW_WAIT,
        S_V,
        S_CHECK,
        S_ADVANCE
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     decode;
        logic     newline;
        logic     tab_prep;
        logic     tab_upd;
        logic     div_start;
        t_div_sel div_sel;
        logic     cols_load;
        logic     u_load;
        logic     row_load;
        logic     v_load;
        logic     out_load;
        logic     adv;
    } t_cmd;

    typedef struct packed {
        logic ch_newline;
        logic ch_tab;
        logic glyph_ok;
        logic step_x_zero;
        logic cols_zero;
        logic v_fits;
        logic out_free;
        logic div_busy;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// File: design/gtl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module gtl_div #(
    parameter int DVW = 17,
    parameter int SW  = 17
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [DVW-1:0]             i_dividend,
    input  wire logic [SW-1:0]              i_divisor,
    input  wire logic [$clog2(DVW+1)-1:0]   i_nbits,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [DVW-1:0]                  o_quot,
    output logic [SW-1:0]                   o_rem
);

    localparam int CNW = $clog2(DVW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DVW-1:0] r_q;
    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_dvs;

    logic [SW:0]    w_trial;
    logic           w_ge;
    logic [SW:0]    w_diff;
    logic [DVW-1:0] n_q;
    logic [SW-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_q[DVW-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[SW-1:0] : w_trial[SW-1:0];
        n_q     = {r_q[DVW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_dvs != '0) |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// File: design/gtl_ctrl.sv
// Sequencing state machine of the glyph text layout block.
`default_nettype none

module gtl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire gtl_pkg::t_sts i_sts,
    output gtl_pkg::t_cmd      o_cmd
);

    import gtl_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                w_cmd.decode = 1'b1;
                priority if (i_sts.ch_newline) begin
                    n_state = S_NEWLINE;
                end else if (i_sts.ch_tab) begin
                    n_state = S_TAB_PREP;
                end else if (i_sts.glyph_ok) begin
                    n_state = S_COLS_GO;
                end else begin
                    n_state = S_ADVANCE;
                end
            end
            S_NEWLINE: begin
                w_cmd.newline = 1'b1;
                n_state       = S_IDLE;
            end
            S_TAB_PREP: begin
                if (i_sts.step_x_zero) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.tab_prep = 1'b1;
                    n_state        = S_TAB_GO;
                end
            end
            S_TAB_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_TAB;
                n_state         = S_TAB_WAIT;
            end
            S_TAB_WAIT: begin
                w_cmd.div_sel = DIV_TAB;
                if (i_sts.div_done) begin
                    n_state = S_TAB_UPD;
                end
            end
            S_TAB_UPD: begin
                w_cmd.tab_upd = 1'b1;
                n_state       = S_IDLE;
            end
            S_COLS_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_COLS;
                n_state         = S_COLS_WAIT;
            end
            S_COLS_WAIT: begin
                w_cmd.div_sel = DIV_COLS;
                if (i_sts.div_done) begin
                    w_cmd.cols_load = 1'b1;
                    n_state         = S_U_GO;
                end
            end
            S_U_GO: begin
                if (i_sts.cols_zero) begin
                    n_state = S_ADVANCE;
                end else begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DIV_U;
                    n_state         = S_U_WAIT;
                end
            end
            S_U_WAIT: begin
                w_cmd.div_sel = DIV_U;
                if (i_sts.div_done) begin
                    w_cmd.u_load = 1'b1;
                    n_state      = S_ROW_GO;
                end
            end
            S_ROW_GO: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_ROW;
                n_state         = S_ROW_WAIT;
            end
            S_ROW_WAIT: begin
                w_cmd.div_sel = DIV_ROW;
                if (i_sts.div_done) begin
                    w_cmd.row_load = 1'b1;
                    n_state        = S_V;
                end
            end
            S_V: begin
                w_cmd.v_load = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.v_fits) begin
                    w_cmd.adv = 1'b1;
                    n_state   = S_IDLE;
                end else if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.adv      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ADVANCE: begin
                w_cmd.adv = 1'b1;
                n_state   = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> i_sts.out_free)
        else $error("result beat overwrote a pending beat");

endmodule

`default_nettype wire

// File: design/gtl_datapath.sv
// Registers, cursor arithmetic, shared divider and output stage.
`default_nettype none

module gtl_datapath #(
    parameter int COORD_WIDTH = 16,
    parameter int TAB_CELLS   = 4
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire gtl_pkg::t_cmd                        i_cmd,
    output gtl_pkg::t_sts                             o_sts,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [gtl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [gtl_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic [gtl_pkg::CH_W-1:0]             i_ch,
    input  wire logic                                 i_new_text,
    input  wire logic signed [gtl_pkg::IN_COORD_W-1:0] i_origin_x,
    input  wire logic signed [gtl_pkg::IN_COORD_W-1:0] i_origin_y,
    input  wire logic [gtl_pkg::SCALE_W-1:0]          i_scale_x,
    input  wire logic [gtl_pkg::SCALE_W-1:0]          i_scale_y,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [gtl_pkg::OUT_COORD_W-1:0]    o_dest_x,
    output logic signed [gtl_pkg::OUT_COORD_W-1:0]    o_dest_y,
    output logic [gtl_pkg::ATLAS_COORD_W-1:0]         o_src_u,
    output logic [gtl_pkg::ATLAS_COORD_W-1:0]         o_src_v,
    output logic [gtl_pkg::SCALE_W-1:0]               o_out_scale_x,
    output logic [gtl_pkg::SCALE_W-1:0]               o_out_scale_y
);

    import gtl_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = ((CW > IN_COORD_W) ? CW : IN_COORD_W) + 1;
    localparam int SW  = STEP_W + $clog2(TAB_CELLS + 1);
    localparam int EW  = ((DW > SW + 1) ? DW : SW + 1) + 2;
    localparam int CNW = $clog2(DW + 1);

    localparam logic signed [EW-1:0] C_MAX = EW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] C_MIN = -C_MAX - EW'(1);

    function automatic logic signed [CW-1:0] f_sat(input logic signed [EW-1:0] a);
        logic signed [EW-1:0] v;
        v = a;
        if (a > C_MAX) begin
            v = C_MAX;
        end else if (a < C_MIN) begin
            v = C_MIN;
        end
        return v[CW-1:0];
    endfunction

    // configuration
    logic [AW_W-1:0] r_atlas_w;
    logic [AW_W-1:0] r_atlas_h;
    logic [GW_W-1:0] r_glyph_w;
    logic [GW_W-1:0] r_glyph_h;

    // item payload and intermediates
    logic [CH_W-1:0]              r_ch;
    logic                         r_new_text;
    logic signed [IN_COORD_W-1:0] r_ox;
    logic signed [IN_COORD_W-1:0] r_oy;
    logic [SCALE_W-1:0]           r_sx;
    logic [SCALE_W-1:0]           r_sy;
    logic [STEP_W-1:0]            r_step_x;
    logic [STEP_W-1:0]            r_step_y;
    logic [CHGW_W-1:0]            r_chgw;
    logic [SW-1:0]                r_stop;
    logic                         r_tab_neg;
    logic [DW-1:0]                r_tab_mag;
    logic [AW_W-1:0]              r_cols;
    logic [AW_W-1:0]              r_u;
    logic [GLYPH_CODE_W-1:0]      r_row;
    logic [V_W-1:0]               r_v;

    logic signed [CW-1:0] r_cursor_x;
    logic signed [CW-1:0] r_cursor_y;

    logic                         r_out_valid;
    logic [OUT_COORD_W-1:0]       r_dest_x;
    logic [OUT_COORD_W-1:0]       r_dest_y;
    logic [ATLAS_COORD_W-1:0]     r_src_u;
    logic [ATLAS_COORD_W-1:0]     r_src_v;
    logic [SCALE_W-1:0]           r_osx;
    logic [SCALE_W-1:0]           r_osy;

    // divider hookup
    logic [DW-1:0]  w_dvd;
    logic [SW-1:0]  w_dvs;
    logic [CNW-1:0] w_nbits;
    logic           w_div_busy;
    logic           w_div_done;
    logic [DW-1:0]  w_div_q;
    logic [SW-1:0]  w_div_rem;

    // extended arithmetic
    logic signed [EW-1:0] w_cx_e;
    logic signed [EW-1:0] w_cy_e;
    logic signed [EW-1:0] w_ox_e;
    logic signed [EW-1:0] w_oy_e;
    logic signed [EW-1:0] w_step_x_e;
    logic signed [EW-1:0] w_step_y_e;
    logic signed [EW-1:0] w_stop_e;
    logic signed [EW-1:0] w_rem_e;
    logic signed [EW-1:0] w_diff;
    logic signed [EW-1:0] w_mag;
    logic signed [EW-1:0] w_tab_x;
    logic                 w_out_free;

    always_comb begin
        w_cx_e     = EW'(r_cursor_x);
        w_cy_e     = EW'(r_cursor_y);
        w_ox_e     = EW'(r_ox);
        w_oy_e     = EW'(r_oy);
        w_step_x_e = signed'(EW'(r_step_x));
        w_step_y_e = signed'(EW'(r_step_y));
        w_stop_e   = signed'(EW'(r_stop));
        w_rem_e    = signed'(EW'(w_div_rem));
        w_diff     = w_cx_e - w_ox_e;
        w_mag      = w_diff[EW-1] ? -w_diff : w_diff;
        w_tab_x    = r_tab_neg ? (w_cx_e + w_rem_e + w_stop_e)
                               : (w_cx_e - w_rem_e + w_stop_e);
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_TAB: begin
                w_dvd   = r_tab_mag;
                w_dvs   = r_stop;
                w_nbits = CNW'(DW);
            end
            DIV_COLS: begin
                w_dvd   = DW'(r_atlas_w) << (DW - AW_W);
                w_dvs   = SW'(r_glyph_w);
                w_nbits = CNW'(AW_W);
            end
            DIV_U: begin
                w_dvd   = DW'(r_chgw) << (DW - CHGW_W);
                w_dvs   = SW'(r_atlas_w);
                w_nbits = CNW'(CHGW_W);
            end
            DIV_ROW: begin
                w_dvd   = DW'(r_ch[GLYPH_CODE_W-1:0]) << (DW - GLYPH_CODE_W);
                w_dvs   = SW'(r_cols);
                w_nbits = CNW'(GLYPH_CODE_W);
            end
        endcase
    end

    gtl_div #(
        .DVW (DW),
        .SW  (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .i_nbits    (w_nbits),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= AW_W'(128);
            r_atlas_h <= AW_W'(128);
            r_glyph_w <= GW_W'(8);
            r_glyph_h <= GW_W'(16);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ATLAS_WIDTH:  r_atlas_w <= i_cfg_data[AW_W-1:0];
                CFG_ATLAS_HEIGHT: r_atlas_h <= i_cfg_data[AW_W-1:0];
                CFG_GLYPH_WIDTH:  r_glyph_w <= i_cfg_data[GW_W-1:0];
                CFG_GLYPH_HEIGHT: r_glyph_h <= i_cfg_data[GW_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch       <= i_ch;
            r_new_text <= i_new_text;
            r_ox       <= i_origin_x;
            r_oy       <= i_origin_y;
            r_sx       <= i_scale_x;
            r_sy       <= i_scale_y;
        end
        if (i_cmd.decode) begin
            r_step_x <= STEP_W'(r_glyph_w) * STEP_W'(r_sx);
            r_step_y <= STEP_W'(r_glyph_h) * STEP_W'(r_sy);
            r_chgw   <= CHGW_W'(r_ch[GLYPH_CODE_W-1:0]) * CHGW_W'(r_glyph_w);
        end
        if (i_cmd.tab_prep) begin
            r_stop    <= SW'(r_step_x * TAB_CELLS);
            r_tab_neg <= w_diff[EW-1];
            r_tab_mag <= w_mag[DW-1:0];
        end
        if (i_cmd.cols_load) begin
            r_cols <= w_div_q[AW_W-1:0];
        end
        if (i_cmd.u_load) begin
            r_u <= w_div_rem[AW_W-1:0];
        end
        if (i_cmd.row_load) begin
            r_row <= w_div_q[GLYPH_CODE_W-1:0];
        end
        if (i_cmd.v_load) begin
            r_v <= V_W'(r_row) * V_W'(r_glyph_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else begin
            priority if (i_cmd.decode) begin
                if (r_new_text) begin
                    r_cursor_x <= f_sat(w_ox_e);
                    r_cursor_y <= f_sat(w_oy_e);
                end
            end else if (i_cmd.newline) begin
                r_cursor_x <= f_sat(w_ox_e);
                r_cursor_y <= f_sat(w_cy_e + w_step_y_e);
            end else if (i_cmd.tab_upd) begin
                r_cursor_x <= f_sat(w_tab_x);
            end else if (i_cmd.adv) begin
                r_cursor_x <= f_sat(w_cx_e + w_step_x_e);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_dest_x <= w_cx_e[OUT_COORD_W-1:0];
            r_dest_y <= w_cy_e[OUT_COORD_W-1:0];
            r_src_u  <= r_u[ATLAS_COORD_W-1:0];
            r_src_v  <= r_v[ATLAS_COORD_W-1:0];
            r_osx    <= r_sx;
            r_osy    <= r_sy;
        end
    end

    always_comb begin
        o_sts.ch_newline  = r_ch == CODE_NEWLINE;
        o_sts.ch_tab      = r_ch == CODE_TAB;
        o_sts.glyph_ok    = !r_ch[CH_W-1] && (r_atlas_w != '0) && (r_glyph_w != '0);
        o_sts.step_x_zero = r_step_x == '0;
        o_sts.cols_zero   = r_cols == '0;
        o_sts.v_fits      = (VSUM_W'(r_v) + VSUM_W'(r_glyph_h)) <= VSUM_W'(r_atlas_h);
        o_sts.out_free    = w_out_free;
        o_sts.div_busy    = w_div_busy;
        o_sts.div_done    = w_div_done;
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_dest_x      = signed'(r_dest_x);
    assign o_dest_y      = signed'(r_dest_y);
    assign o_src_u       = r_src_u;
    assign o_src_v       = r_src_v;
    assign o_out_scale_x = r_osx;
    assign o_out_scale_y = r_osy;

endmodule

`default_nettype wire

// File: design/glyph_text_layout.sv
// Top level of the glyph text layout block.
// Takes one character beat at a time and keeps a text cursor. A newline or
// a tab only moves the cursor. Any other code 0..127 yields one beat with
// the glyph's atlas cell and screen position, provided the cell fits in the
// atlas, and then advances the cursor one scaled glyph width. Codes above
// 127 and glyphs that do not fit yield nothing but still advance the cursor.
// The cursor saturates at the signed COORD_WIDTH range. Items are handled
// one at a time by a shared bit-serial divider. A newline, a tab with zero
// step, a code above 127 or a zero atlas or glyph width needs no division.
// A tab waits on one division over the cursor offset. A code skipped for a
// zero column count ends after the column division. Any other code 0..127
// waits on the three divisions for column count, cell u and cell row,
// whether or not the cell fits. A finished beat waits in an output
// register, so the next character is taken meanwhile. If that register
// still holds an unaccepted beat, the next glyph beat holds in its last
// step until the register drains.
// Configuration writes are always ready and take effect at once.
`default_nettype none

module glyph_text_layout #(
    parameter int COORD_WIDTH = 16,
    parameter int TAB_CELLS   = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [gtl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [gtl_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [gtl_pkg::CH_W-1:0]              i_ch,
    input  wire logic                                  i_new_text,
    input  wire logic signed [gtl_pkg::IN_COORD_W-1:0] i_origin_x,
    input  wire logic signed [gtl_pkg::IN_COORD_W-1:0] i_origin_y,
    input  wire logic [gtl_pkg::SCALE_W-1:0]           i_scale_x,
    input  wire logic [gtl_pkg::SCALE_W-1:0]           i_scale_y,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [gtl_pkg::OUT_COORD_W-1:0]     o_dest_x,
    output logic signed [gtl_pkg::OUT_COORD_W-1:0]     o_dest_y,
    output logic [gtl_pkg::ATLAS_COORD_W-1:0]          o_src_u,
    output logic [gtl_pkg::ATLAS_COORD_W-1:0]          o_src_v,
    output logic [gtl_pkg::SCALE_W-1:0]                o_out_scale_x,
    output logic [gtl_pkg::SCALE_W-1:0]                o_out_scale_y
);

    import gtl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    gtl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gtl_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .TAB_CELLS   (TAB_CELLS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ch          (i_ch),
        .i_new_text    (i_new_text),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_scale_x     (i_scale_x),
        .i_scale_y     (i_scale_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_dest_x      (o_dest_x),
        .o_dest_y      (o_dest_y),
        .o_src_u       (o_src_u),
        .o_src_v       (o_src_v),
        .o_out_scale_x (o_out_scale_x),
        .o_out_scale_y (o_out_scale_y)
    );

endmodule

`default_nettype wire
